@@ rtl/lpt_pkg.sv @@
// Shared types and constants for the listen port table.
// No dependencies; compiled first.
`default_nettype none

package lpt_pkg;

	localparam int LPT_TABLE_DEPTH = 16;

	localparam int OP_W    = 2;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int OWNER_W = 8;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 4;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OCCUPIED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [PORT_W-1:0]  port;
		logic [OWNER_W-1:0] owner;
	} entry_t;

endpackage

`default_nettype wire

@@ rtl/lpt_req_if.sv @@
// Request channel of the listen port table: valid, ready and request word.
// Depends on lpt_pkg for field widths.
`default_nettype none

interface lpt_req_if import lpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [IP_W-1:0]    ip_addr;
	logic [PORT_W-1:0]  port_num;
	logic [OWNER_W-1:0] owner_id;

	modport source (output valid, output opcode, output ip_addr, output port_num,
		output owner_id, input ready);
	modport sink (input valid, input opcode, input ip_addr, input port_num,
		input owner_id, output ready);
endinterface

`default_nettype wire

@@ rtl/lpt_rsp_if.sv @@
// Response channel of the listen port table: valid, ready and result word.
// Depends on lpt_pkg for field widths.
`default_nettype none

interface lpt_rsp_if import lpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [OWNER_W-1:0] found_owner;
	logic [SLOT_W-1:0]  slot_index;

	modport source (output valid, output status, output found_owner,
		output slot_index, input ready);
	modport sink (input valid, input status, input found_owner,
		input slot_index, output ready);
endinterface

`default_nettype wire

@@ rtl/lpt_entry_ram.sv @@
// Entry store of the listen port table: address, port and owner per slot.
// One write port, one read port with registered data. Depends on lpt_pkg.
`default_nettype none

module lpt_entry_ram import lpt_pkg::*; #(
	parameter int DEPTH = LPT_TABLE_DEPTH,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire entry_t           wdata,
	input  wire logic             re,
	input  wire logic [IDX_W-1:0] raddr,
	output entry_t                rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/listen_port_table.sv @@
// Listen port table: a request word is taken only while the table is idle, and no new
// one is taken until its result word is formed, after the scan of every slot
// through the single read port of the entry memory, one slot a cycle.
// A result waits in an output register; the next request is taken meanwhile.
// Reset clears all valid bits at once; the entry memory holds no reset.
// Depends on lpt_pkg, lpt_req_if, lpt_rsp_if and lpt_entry_ram.
`default_nettype none

module listen_port_table import lpt_pkg::*; #(
	parameter int TABLE_DEPTH = LPT_TABLE_DEPTH
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lpt_req_if.sink   req,
	lpt_rsp_if.source rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   iss_q;
	logic [IDX_W-1:0]       cnt_q;
	logic                   cmp_s1;
	logic [IDX_W-1:0]       idx_s1;

	logic [OP_W-1:0]        op_q;
	entry_t                 key_q;

	logic                   clash_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic [OWNER_W-1:0]     hit_owner_q;

	logic                   rsp_valid_q;
	logic [STAT_W-1:0]      rsp_status_q;
	logic [OWNER_W-1:0]     rsp_owner_q;
	logic [SLOT_W-1:0]      rsp_slot_q;

	entry_t                 rd_entry;
	logic                   slot_valid;
	logic                   match_addr;
	logic                   match_owner;
	logic                   match_sel;
	logic                   req_fire;
	logic                   done_fire;
	logic                   add_ok;

	logic [STAT_W-1:0]      res_status;
	logic [OWNER_W-1:0]     res_owner;
	logic [IDX_W-1:0]       res_idx;

	lpt_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (done_fire && add_ok),
		.waddr (free_idx_q),
		.wdata (key_q),
		.re    (iss_q),
		.raddr (cnt_q),
		.rdata (rd_entry)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign done_fire  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign slot_valid  = valid_q[idx_s1];
	assign match_addr  = slot_valid && (rd_entry.ip == key_q.ip)
		&& (rd_entry.port == key_q.port);
	assign match_owner = slot_valid && (rd_entry.owner == key_q.owner);
	assign match_sel   = (op_q == OP_REMOVE) ? match_owner : match_addr;
	assign add_ok      = (op_q == OP_ADD) && !clash_q && free_q;

	always_comb begin
		res_status = ST_NOT_FOUND;
		res_owner  = '0;
		res_idx    = '0;
		unique case (op_q)
			OP_ADD: begin
				if (clash_q) begin
					res_status = ST_OCCUPIED;
				end else if (!free_q) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_OK;
					res_idx    = free_idx_q;
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					res_status = ST_OK;
					res_idx    = hit_idx_q;
				end
			end
			OP_SEARCH: begin
				if (hit_q) begin
					res_status = ST_OK;
					res_owner  = hit_owner_q;
					res_idx    = hit_idx_q;
				end
			end
			default: begin
				res_status = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q   <= 1'b0;
			cnt_q   <= '0;
			cmp_s1  <= 1'b0;
			clash_q <= 1'b0;
			free_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			cmp_s1 <= iss_q;
			if (iss_q) begin
				if (cnt_q == LAST_IDX) begin
					iss_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_SCAN;
						iss_q   <= 1'b1;
						cnt_q   <= '0;
						clash_q <= 1'b0;
						free_q  <= 1'b0;
						hit_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					if (cmp_s1) begin
						if (match_addr) begin
							clash_q <= 1'b1;
						end
						if (!slot_valid && !free_q) begin
							free_q <= 1'b1;
						end
						if (match_sel && !hit_q) begin
							hit_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (req_fire) begin
			op_q        <= req.opcode;
			key_q.ip    <= req.ip_addr;
			key_q.port  <= req.port_num;
			key_q.owner <= req.owner_id;
		end
		if ((state_q == S_SCAN) && cmp_s1) begin
			if (!slot_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (match_sel && !hit_q) begin
				hit_idx_q   <= idx_s1;
				hit_owner_q <= rd_entry.owner;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (done_fire) begin
			if (add_ok) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if ((op_q == OP_REMOVE) && hit_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			rsp_status_q <= res_status;
			rsp_owner_q  <= res_owner;
			rsp_slot_q   <= SLOT_W'(res_idx);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.found_owner = rsp_owner_q;
	assign rsp.slot_index  = rsp_slot_q;

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!iss_q && !cmp_s1))
		else $error("scan activity while idle");

	a_issue_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		iss_q |-> (state_q == S_SCAN))
		else $error("memory read issued outside scan");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && add_ok) |=> valid_q[$past(free_idx_q)])
		else $error("successful add left slot invalid");

	a_done_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> (rsp_valid_q && (state_q == S_IDLE)))
		else $error("finished request did not reach output register");
`endif

endmodule

`default_nettype wire
